// ===== sv/light_effect_range_assert.svh =====
// Assertion macros used by the light effect range checker.
`ifndef LIGHT_EFFECT_RANGE_ASSERT_SVH
`define LIGHT_EFFECT_RANGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LER_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LER_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ler_pkg.sv =====
// Types, constants and a helper function shared by the light effect range block.
`timescale 1ns / 1ps

package ler_pkg;

    localparam int MODE_W  = 3;
    localparam int TERM_W  = 24;
    localparam int POW_W   = 24;
    localparam int RAD_W   = 32;
    localparam int DIST_W  = 10;
    localparam int P_W     = 31;
    localparam int QD_W    = 34;
    localparam int U_W     = 35;
    localparam int M_W     = 45;
    localparam int ATT_W   = 46;
    localparam int DELTA_W = 36;
    localparam int SQ_W    = 48;
    localparam int SUM_W   = 50;
    localparam int ROOT_W  = 25;
    localparam int REM_W   = 28;
    localparam int CNT_W   = 5;
    localparam int PIDX_W  = 3;

    localparam logic [MODE_W-1:0] MODE_POINT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SPOT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BOX    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SPHERE = 3'd3;

    localparam logic [DIST_W-1:0] DIST_MAX = 10'd1023;

    // Probe order of the coarse search.
    localparam logic [PIDX_W-1:0] PRB_1000 = 3'd0;
    localparam logic [PIDX_W-1:0] PRB_20   = 3'd1;
    localparam logic [PIDX_W-1:0] PRB_750  = 3'd2;
    localparam logic [PIDX_W-1:0] PRB_50   = 3'd3;
    localparam logic [PIDX_W-1:0] PRB_100  = 3'd4;
    localparam logic [PIDX_W-1:0] PRB_500  = 3'd5;
    localparam logic [PIDX_W-1:0] PRB_250  = 3'd6;

    // Walk start points picked by the probes.
    localparam logic [DIST_W-1:0] START_0   = 10'd0;
    localparam logic [DIST_W-1:0] START_21  = 10'd21;
    localparam logic [DIST_W-1:0] START_51  = 10'd51;
    localparam logic [DIST_W-1:0] START_101 = 10'd101;
    localparam logic [DIST_W-1:0] START_250 = 10'd250;
    localparam logic [DIST_W-1:0] START_500 = 10'd500;
    localparam logic [DIST_W-1:0] START_750 = 10'd750;

    // Last count values of the square accumulation and of the 25-step square root.
    localparam logic [CNT_W-1:0] SQ_LAST   = 5'd4;
    localparam logic [CNT_W-1:0] ROOT_LAST = 5'd24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MUL1,
        ST_MUL2,
        ST_ADD,
        ST_PROBE,
        ST_DELTA,
        ST_WALK,
        ST_SQ,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RES_DIST,
        RES_ROOT,
        RES_CONST,
        RES_INF
    } res_t;

    typedef enum logic [1:0] {
        SQ_C,
        SQ_L,
        SQ_Q
    } sq_sel_t;

    typedef struct packed {
        logic              load;
        logic              mul1;
        logic              mul2;
        logic              add;
        logic              d_load;
        logic [DIST_W-1:0] d_val;
        logic              delta;
        logic              walk;
        logic              sq_clr;
        logic              sq_mul;
        logic              sq_acc;
        sq_sel_t           sq_sel;
        logic              rt_init;
        logic              rt_step;
        logic              out_write;
        res_t              res_sel;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              att_lt;
        logic              att_gt;
        logic              d_max;
        logic              out_free;
    } stat_t;

    function automatic logic [DIST_W-1:0] probe_dist(input logic [PIDX_W-1:0] idx);
        logic [DIST_W-1:0] d;
        unique case (idx)
            PRB_1000: d = 10'd1000;
            PRB_20:   d = 10'd20;
            PRB_750:  d = 10'd750;
            PRB_50:   d = 10'd50;
            PRB_100:  d = 10'd100;
            PRB_500:  d = 10'd500;
            PRB_250:  d = 10'd250;
            default:  d = 10'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/light_effect_range.sv =====
// Top level of the light effect range block: controller plus datapath.
//
//  Channel   Valid      Stall      Word fields
//  -------   ---------  ---------  ------------------------------------------------
//  input     in_valid   in_stall   mode, const_term, linear_term, quad_term, light_power
//  output    out_valid  out_stall  radius, is_infinite
//
// One light is worked on at a time.
// Point/spot: k probes (2 to 7), then n unit walk steps; unbounded ends at the first probe.
// The longest walk, 922 steps from 101 to 1023, needs attenuation flat at the threshold.
// Ambient box lights take the 25-step root of the summed squares; sphere/unknown skip it.
// Reset is asynchronous and active low; it clears the state machine and output valid.
// A stalled result sits in the output register while the next word is accepted and worked on.
`timescale 1ns / 1ps

module light_effect_range
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ler_pkg::MODE_W-1:0]        mode,
    input  logic [ler_pkg::TERM_W-1:0]        const_term,
    input  logic [ler_pkg::TERM_W-1:0]        linear_term,
    input  logic [ler_pkg::TERM_W-1:0]        quad_term,
    input  logic signed [ler_pkg::POW_W-1:0]  light_power,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ler_pkg::RAD_W-1:0]         radius,
    output logic                              is_infinite
);

    // Commands flow from the controller to the datapath, status flows back.
    ler_pkg::cmd_t  cmd;
    ler_pkg::stat_t stat;

    // The controller walks a light through its type-specific sequence and
    // raises in_stall for as long as a light is in flight.
    ler_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the operands, the attenuation evaluator, the walk
    // adders, the square root unit and the output register.
    ler_datapath
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .const_term  (const_term),
        .linear_term (linear_term),
        .quad_term   (quad_term),
        .light_power (light_power),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .radius      (radius),
        .is_infinite (is_infinite)
    );

endmodule

// ===== sv/ler_ctrl.sv =====
// Controller state machine that sequences probes, the walk and the square root.
`timescale 1ns / 1ps

module ler_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ler_pkg::stat_t stat,
    output ler_pkg::cmd_t  cmd
);

    ler_pkg::state_t                   state_reg, state_next;
    logic [ler_pkg::PIDX_W-1:0]        probe_reg, probe_next;
    logic [ler_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                              walk_mode_reg, walk_mode_next;
    ler_pkg::res_t                     res_reg, res_next;

    logic                              advance;
    logic                              start;
    logic [ler_pkg::DIST_W-1:0]        start_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ler_pkg::ST_IDLE;
            probe_reg     <= ler_pkg::PRB_1000;
            cnt_reg       <= '0;
            walk_mode_reg <= 1'b0;
            res_reg       <= ler_pkg::RES_INF;
        end
        else
        begin
            state_reg     <= state_next;
            probe_reg     <= probe_next;
            cnt_reg       <= cnt_next;
            walk_mode_reg <= walk_mode_next;
            res_reg       <= res_next;
        end
    end

    assign in_stall = (state_reg != ler_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        probe_next     = probe_reg;
        cnt_next       = cnt_reg;
        walk_mode_next = walk_mode_reg;
        res_next       = res_reg;
        cmd            = '0;
        advance        = 1'b0;
        start          = 1'b0;
        start_d        = ler_pkg::START_101;

        unique case (state_reg)
            ler_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ler_pkg::ST_START;
                end
            end

            ler_pkg::ST_START:
            begin
                if (stat.mode == ler_pkg::MODE_POINT || stat.mode == ler_pkg::MODE_SPOT)
                begin
                    cmd.d_load     = 1'b1;
                    cmd.d_val      = ler_pkg::probe_dist(ler_pkg::PRB_1000);
                    probe_next     = ler_pkg::PRB_1000;
                    walk_mode_next = 1'b0;
                    state_next     = ler_pkg::ST_MUL1;
                end
                else if (stat.mode == ler_pkg::MODE_BOX)
                begin
                    cnt_next   = '0;
                    state_next = ler_pkg::ST_SQ;
                end
                else if (stat.mode == ler_pkg::MODE_SPHERE)
                begin
                    res_next   = ler_pkg::RES_CONST;
                    state_next = ler_pkg::ST_DONE;
                end
                else
                begin
                    res_next   = ler_pkg::RES_INF;
                    state_next = ler_pkg::ST_DONE;
                end
            end

            ler_pkg::ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ler_pkg::ST_MUL2;
            end

            ler_pkg::ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ler_pkg::ST_ADD;
            end

            ler_pkg::ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = walk_mode_reg ? ler_pkg::ST_DELTA : ler_pkg::ST_PROBE;
            end

            ler_pkg::ST_PROBE:
            begin
                unique case (probe_reg)
                    ler_pkg::PRB_1000:
                    begin
                        if (stat.att_lt)
                        begin
                            res_next   = ler_pkg::RES_INF;
                            state_next = ler_pkg::ST_DONE;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    ler_pkg::PRB_20:
                    begin
                        start   = stat.att_gt;
                        advance = !stat.att_gt;
                        start_d = ler_pkg::START_0;
                    end
                    ler_pkg::PRB_750:
                    begin
                        start   = stat.att_lt;
                        advance = !stat.att_lt;
                        start_d = ler_pkg::START_750;
                    end
                    ler_pkg::PRB_50:
                    begin
                        start   = stat.att_gt;
                        advance = !stat.att_gt;
                        start_d = ler_pkg::START_21;
                    end
                    ler_pkg::PRB_100:
                    begin
                        start   = stat.att_gt;
                        advance = !stat.att_gt;
                        start_d = ler_pkg::START_51;
                    end
                    ler_pkg::PRB_500:
                    begin
                        start   = stat.att_lt;
                        advance = !stat.att_lt;
                        start_d = ler_pkg::START_500;
                    end
                    ler_pkg::PRB_250:
                    begin
                        start   = 1'b1;
                        start_d = stat.att_lt ? ler_pkg::START_250 : ler_pkg::START_101;
                    end
                    default:
                    begin
                        res_next   = ler_pkg::RES_INF;
                        state_next = ler_pkg::ST_DONE;
                    end
                endcase

                if (advance)
                begin
                    probe_next = probe_reg + 3'd1;
                    cmd.d_load = 1'b1;
                    cmd.d_val  = ler_pkg::probe_dist(probe_reg + 3'd1);
                    state_next = ler_pkg::ST_MUL1;
                end
                else if (start)
                begin
                    cmd.d_load     = 1'b1;
                    cmd.d_val      = start_d;
                    walk_mode_next = 1'b1;
                    state_next     = ler_pkg::ST_MUL1;
                end
            end

            ler_pkg::ST_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = ler_pkg::ST_WALK;
            end

            ler_pkg::ST_WALK:
            begin
                if (stat.att_gt || stat.d_max)
                begin
                    res_next   = ler_pkg::RES_DIST;
                    state_next = ler_pkg::ST_DONE;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end

            ler_pkg::ST_SQ:
            begin
                // Square of one term per cycle; each product joins the sum in the cycle after it is registered.
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0:
                    begin
                        cmd.sq_clr = 1'b1;
                        cmd.sq_mul = 1'b1;
                        cmd.sq_sel = ler_pkg::SQ_C;
                    end
                    5'd1:
                    begin
                        cmd.sq_acc = 1'b1;
                        cmd.sq_mul = 1'b1;
                        cmd.sq_sel = ler_pkg::SQ_L;
                    end
                    5'd2:
                    begin
                        cmd.sq_acc = 1'b1;
                        cmd.sq_mul = 1'b1;
                        cmd.sq_sel = ler_pkg::SQ_Q;
                    end
                    5'd3:
                    begin
                        cmd.sq_acc = 1'b1;
                    end
                    default:
                    begin
                        cmd.rt_init = 1'b1;
                        cnt_next    = '0;
                        state_next  = ler_pkg::ST_ROOT;
                    end
                endcase
                if (cnt_reg > ler_pkg::SQ_LAST)
                begin
                    cnt_next = '0;
                end
            end

            ler_pkg::ST_ROOT:
            begin
                cmd.rt_step = 1'b1;
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == ler_pkg::ROOT_LAST)
                begin
                    res_next   = ler_pkg::RES_ROOT;
                    state_next = ler_pkg::ST_DONE;
                end
            end

            ler_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_write = 1'b1;
                    cmd.res_sel   = res_reg;
                    state_next    = ler_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ler_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ler_datapath.sv =====
// Datapath: operand registers, attenuation evaluator, walk adders, root unit, output register.
`timescale 1ns / 1ps

module ler_datapath
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ler_pkg::MODE_W-1:0]          mode,
    input  logic [ler_pkg::TERM_W-1:0]          const_term,
    input  logic [ler_pkg::TERM_W-1:0]          linear_term,
    input  logic [ler_pkg::TERM_W-1:0]          quad_term,
    input  logic signed [ler_pkg::POW_W-1:0]    light_power,
    input  ler_pkg::cmd_t                       cmd,
    output ler_pkg::stat_t                      stat,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [ler_pkg::RAD_W-1:0]           radius,
    output logic                                is_infinite
);

    logic [ler_pkg::MODE_W-1:0]  mode_reg;
    logic [ler_pkg::TERM_W-1:0]  c_reg;
    logic [ler_pkg::TERM_W-1:0]  l_reg;
    logic [ler_pkg::TERM_W-1:0]  q_reg;
    logic [ler_pkg::P_W-1:0]     p_reg;
    logic [ler_pkg::DIST_W-1:0]  d_reg;
    logic [ler_pkg::QD_W-1:0]    qd_reg;
    logic [ler_pkg::M_W-1:0]     m_reg;
    logic [ler_pkg::ATT_W-1:0]   att_reg;
    logic [ler_pkg::DELTA_W-1:0] delta_reg;
    logic [ler_pkg::SQ_W-1:0]    prod_reg;
    logic [ler_pkg::SUM_W-1:0]   sum_reg;
    logic [ler_pkg::SUM_W-1:0]   rad_reg;
    logic [ler_pkg::REM_W-1:0]   rem_reg;
    logic [ler_pkg::ROOT_W-1:0]  root_reg;
    logic                        out_valid_reg;
    logic [ler_pkg::RAD_W-1:0]   radius_reg;
    logic                        inf_reg;

    logic [ler_pkg::POW_W-1:0]   mag;
    logic [ler_pkg::RAD_W-1:0]   p_full;
    logic [ler_pkg::U_W-1:0]     u_sum;
    logic [ler_pkg::TERM_W-1:0]  sq_op;
    logic [ler_pkg::REM_W-1:0]   rem_sh;
    logic [ler_pkg::REM_W-1:0]   trial;
    logic [ler_pkg::RAD_W-1:0]   dist_fx;

    // Magnitude of the intensity; the most negative code maps onto itself.
    assign mag    = light_power[ler_pkg::POW_W-1] ? (~light_power + 24'd1) : light_power;
    // 255 * |I| as a shift and a subtract.
    assign p_full = {mag, 8'd0} - ler_pkg::RAD_W'(mag);

    assign u_sum  = ler_pkg::U_W'(qd_reg) + ler_pkg::U_W'(l_reg);

    always_comb
    begin
        case (cmd.sq_sel)
            ler_pkg::SQ_C: sq_op = c_reg;
            ler_pkg::SQ_L: sq_op = l_reg;
            ler_pkg::SQ_Q: sq_op = q_reg;
            default:       sq_op = '0;
        endcase
    end

    assign rem_sh = {rem_reg[ler_pkg::REM_W-3:0], rad_reg[ler_pkg::SUM_W-1 -: 2]};
    assign trial  = ler_pkg::REM_W'({root_reg, 2'b01});

    assign dist_fx = ler_pkg::RAD_W'(ler_pkg::RAD_W'(d_reg) << FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            c_reg    <= const_term;
            l_reg    <= linear_term;
            q_reg    <= quad_term;
            p_reg    <= p_full[ler_pkg::P_W-1:0];
        end

        if (cmd.d_load)
        begin
            d_reg <= cmd.d_val;
        end
        else if (cmd.walk)
        begin
            d_reg <= d_reg + 10'd1;
        end

        // att(d) = c + d * (l + q * d), one multiplication per cycle.
        if (cmd.mul1)
        begin
            qd_reg <= ler_pkg::QD_W'(q_reg) * ler_pkg::QD_W'(d_reg);
        end
        if (cmd.mul2)
        begin
            m_reg <= ler_pkg::M_W'(u_sum) * ler_pkg::M_W'(d_reg);
        end

        if (cmd.add)
        begin
            att_reg <= ler_pkg::ATT_W'(c_reg) + ler_pkg::ATT_W'(m_reg);
        end
        else if (cmd.walk)
        begin
            att_reg <= att_reg + ler_pkg::ATT_W'(delta_reg);
        end

        // First difference att(d+1) - att(d) = l + q * (2d + 1), then grows by 2q a step.
        if (cmd.delta)
        begin
            delta_reg <= ler_pkg::DELTA_W'(l_reg) + ler_pkg::DELTA_W'({qd_reg, 1'b0})
                         + ler_pkg::DELTA_W'(q_reg);
        end
        else if (cmd.walk)
        begin
            delta_reg <= delta_reg + ler_pkg::DELTA_W'({q_reg, 1'b0});
        end

        if (cmd.sq_mul)
        begin
            prod_reg <= ler_pkg::SQ_W'(sq_op) * ler_pkg::SQ_W'(sq_op);
        end
        if (cmd.sq_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sq_acc)
        begin
            sum_reg <= sum_reg + ler_pkg::SUM_W'(prod_reg);
        end

        // Restoring square root, one result bit per step.
        if (cmd.rt_init)
        begin
            rad_reg  <= sum_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.rt_step)
        begin
            rad_reg <= {rad_reg[ler_pkg::SUM_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ler_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ler_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        if (cmd.out_write)
        begin
            case (cmd.res_sel)
                ler_pkg::RES_DIST:
                begin
                    radius_reg <= dist_fx;
                    inf_reg    <= 1'b0;
                end
                ler_pkg::RES_ROOT:
                begin
                    radius_reg <= ler_pkg::RAD_W'(root_reg);
                    inf_reg    <= 1'b0;
                end
                ler_pkg::RES_CONST:
                begin
                    radius_reg <= ler_pkg::RAD_W'(c_reg);
                    inf_reg    <= 1'b0;
                end
                default:
                begin
                    radius_reg <= '0;
                    inf_reg    <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.mode     = mode_reg;
    assign stat.att_lt   = att_reg < ler_pkg::ATT_W'(p_reg);
    assign stat.att_gt   = att_reg > ler_pkg::ATT_W'(p_reg);
    assign stat.d_max    = (d_reg == ler_pkg::DIST_MAX);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign radius      = radius_reg;
    assign is_infinite = inf_reg;

endmodule

// ===== sv/ler_checker.sv =====
// Port-level checker for the light effect range block and its bind statement.
`timescale 1ns / 1ps
`include "light_effect_range_assert.svh"

module ler_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [ler_pkg::RAD_W-1:0] radius,
    input logic                      is_infinite
);

    // An unbounded result always carries a zero radius.
    `LER_ASSERT_IMP(a_inf_zero, clk, rst_n, out_valid && is_infinite, radius == '0, "infinite result with nonzero radius")

    // After a word is taken the block is busy on it.
    `LER_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after accept")

    // A result only appears while a light was in flight.
    `LER_ASSERT_IMP(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result without work in flight")

    // A stalled result holds.
    `LER_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(radius) && $stable(is_infinite), "stalled result changed")

endmodule

bind light_effect_range ler_checker u_ler_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .radius      (radius),
    .is_infinite (is_infinite)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the light effect range block.
`timescale 1ns / 1ps

module tb;

    import ler_pkg::*;

    // Fixed-point format and run bounds.
    localparam int          FRAC         = 16;
    localparam int          RANDOM_WORDS = 800;
    localparam int          DRAIN_CYCLES = 400;
    localparam int          LIMIT_CYCLES = 3000000;
    localparam int          PRINT_CAP    = 200;

    // Codes of the types that the block does not know.
    localparam logic [MODE_W-1:0] MODE_UNK_LO = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNK_HI = 3'd7;

    // Intensity extremes and -1 in raw two's complement, with term constants.
    localparam logic [POW_W-1:0]  POW_MAX  = 24'h7FFFFF;
    localparam logic [POW_W-1:0]  POW_MIN  = 24'h800000;
    localparam logic [POW_W-1:0]  POW_NEG1 = 24'hFFFFFF;
    localparam logic [TERM_W-1:0] TERM_MAX = 24'hFFFFFF;
    localparam logic [TERM_W-1:0] ONE_Q    = 24'h010000;

    // Largest intensity magnitude that still fits the field as a positive value.
    localparam longint unsigned MAG_MAX = 64'd8388607;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TERM_W-1:0] c;
        logic [TERM_W-1:0] l;
        logic [TERM_W-1:0] q;
        logic [POW_W-1:0]  pw;
    } light_t;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic             inf;
    } range_t;

    typedef struct {
        light_t light;
        bit     known;
        range_t res;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [MODE_W-1:0]         mode;
    logic [TERM_W-1:0]         const_term;
    logic [TERM_W-1:0]         linear_term;
    logic [TERM_W-1:0]         quad_term;
    logic signed [POW_W-1:0]   light_power;
    logic                      out_valid;
    logic                      out_stall;
    logic [RAD_W-1:0]          radius;
    logic                      is_infinite;

    // Ranges still owed by the block, oldest first.
    range_t      pending_ranges[$];
    row_t        directed_rows[$];
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned in_gap_pct;
    int unsigned out_stall_pct;

    light_effect_range #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .const_term  (const_term),
        .linear_term (linear_term),
        .quad_term   (quad_term),
        .light_power (light_power),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .radius      (radius),
        .is_infinite (is_infinite)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Attenuation c + l*d + q*d*d, exact in 64 bits for every legal term and d <= 1023.
    function automatic longint unsigned attenuation(input light_t w, input longint unsigned d);
        return longint'(w.c) + longint'(w.l) * d + longint'(w.q) * d * d;
    endfunction

    // Floor of the square root, built one result bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 25; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // Expected range of one light.
    function automatic range_t predict_range(input light_t w);
        range_t          r;
        logic [POW_W-1:0] mag_bits;
        longint unsigned power;
        longint unsigned d;
        r.radius = '0;
        r.inf    = 1'b0;
        // Negating the most negative value wraps back to itself, which is its magnitude.
        mag_bits = w.pw[POW_W-1] ? POW_W'(-w.pw) : w.pw;
        power    = 64'd255 * longint'(mag_bits);
        if (w.mode == MODE_POINT || w.mode == MODE_SPOT)
        begin
            if (attenuation(w, 1000) < power)
                r.inf = 1'b1;
            else
            begin
                // Coarse probes pick where the unit-step walk begins.
                if (attenuation(w, 20) > power)
                    d = 0;
                else if (attenuation(w, 750) < power)
                    d = 750;
                else if (attenuation(w, 50) > power)
                    d = 21;
                else if (attenuation(w, 100) > power)
                    d = 51;
                else if (attenuation(w, 500) < power)
                    d = 500;
                else if (attenuation(w, 250) < power)
                    d = 250;
                else
                    d = 101;
                while (d < longint'(DIST_MAX) && !(attenuation(w, d) > power))
                    d++;
                r.radius = RAD_W'(d << FRAC);
            end
        end
        else if (w.mode == MODE_BOX)
            r.radius = RAD_W'(floor_root(longint'(w.c) * w.c + longint'(w.l) * w.l
                                         + longint'(w.q) * w.q));
        else if (w.mode == MODE_SPHERE)
            r.radius = RAD_W'(w.c);
        else
            r.inf = 1'b1;
        return r;
    endfunction

    task automatic add_row(input logic [MODE_W-1:0] m, input logic [TERM_W-1:0] c,
                           input logic [TERM_W-1:0] l, input logic [TERM_W-1:0] q,
                           input logic [POW_W-1:0] pw, input bit known,
                           input logic [RAD_W-1:0] rad, input logic inf);
        row_t row;
        row.light      = '{mode: m, c: c, l: l, q: q, pw: pw};
        row.known      = known;
        row.res.radius = rad;
        row.res.inf    = inf;
        directed_rows.push_back(row);
    endtask

    // Random light. Most point and spot lights are aimed at a chosen radius so that
    // every probe outcome and walk length is reached; the rest is raw noise.
    function automatic light_t random_light();
        light_t          w;
        longint unsigned target_d;
        longint unsigned a;
        longint unsigned m;
        int unsigned     pick;
        pick   = $urandom_range(99);
        w.mode = MODE_W'($urandom);
        w.c    = TERM_W'($urandom);
        w.l    = TERM_W'($urandom);
        w.q    = TERM_W'($urandom);
        w.pw   = POW_W'($urandom);
        if (pick < 15)
            return w;
        if (pick < 25)
        begin
            w.mode = MODE_BOX;
            if ($urandom_range(1) == 0)
            begin
                w.c = TERM_W'($urandom_range(0, 4095));
                w.l = TERM_W'($urandom_range(0, 4095));
                w.q = TERM_W'($urandom_range(0, 4095));
            end
            return w;
        end
        if (pick < 31)
        begin
            w.mode = MODE_SPHERE;
            return w;
        end
        if (pick < 35)
        begin
            w.mode = MODE_W'($urandom_range(MODE_UNK_LO, MODE_UNK_HI));
            return w;
        end
        w.mode   = ($urandom_range(1) == 0) ? MODE_POINT : MODE_SPOT;
        target_d = $urandom_range(0, 1000);
        case ($urandom_range(3))
            0:       w.q = '0;
            1:       w.q = TERM_W'($urandom_range(0, 255));
            default: w.q = TERM_W'($urandom_range(0, 65535));
        endcase
        w.l = ($urandom_range(4) == 0) ? '0 : TERM_W'($urandom_range(0, 1 << 20));
        w.c = TERM_W'($urandom_range(0, 1 << 22));
        a   = attenuation(w, target_d);
        // Scale the slopes down until the needed intensity fits the field.
        while (a / 255 > MAG_MAX)
        begin
            w.q = w.q >> 1;
            w.l = w.l >> 1;
            a   = attenuation(w, target_d);
        end
        m = a / 255;
        case ($urandom_range(9))
            0:
            begin
                // Brighter than the attenuation at the far probe: unbounded.
                m = attenuation(w, 1000) / 255 + 1 + $urandom_range(0, 100);
            end
            1:
            begin
                // Flat attenuation equal to the threshold: the walk runs to its limit.
                w.l = '0;
                w.q = '0;
                m   = $urandom_range(0, 65535);
                w.c = TERM_W'(m * 255);
            end
            default:
            begin
                m = m + $urandom_range(0, 2);
                if (m > 0)
                    m = m - 1;
            end
        endcase
        if (m > MAG_MAX)
            m = MAG_MAX;
        w.pw = ($urandom_range(1) == 0) ? POW_W'(m) : POW_W'(-m);
        return w;
    endfunction

    // Presents one word after a random gap and holds it until the block takes it.
    // Entered and left at a falling edge.
    task automatic send_light(input light_t w, input range_t want);
        while ($urandom_range(99) < in_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        mode        = w.mode;
        const_term  = w.c;
        linear_term = w.l;
        quad_term   = w.q;
        light_power = w.pw;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_ranges.push_back(want);
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Every word that leaves the block is checked against the oldest expectation.
    always @(posedge clk)
    begin
        range_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ranges.size() == 0)
                report_mismatch($sformatf("unexpected word radius=%h inf=%b",
                                          radius, is_infinite));
            else
            begin
                want = pending_ranges.pop_front();
                if (radius !== want.radius)
                    report_mismatch($sformatf("radius %h, expected %h", radius, want.radius));
                if (is_infinite !== want.inf)
                    report_mismatch($sformatf("is_infinite %b, expected %b",
                                              is_infinite, want.inf));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        range_t want;
        light_t w;
        mismatches    = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = '0;
        const_term    = '0;
        linear_term   = '0;
        quad_term     = '0;
        light_power   = '0;
        in_gap_pct    = 29;
        out_stall_pct = 46;

        // Directed rows. Typed results are the obvious ones; the rest go to the predictor.
        // Unknown types are unbounded with a zero radius.
        add_row(MODE_UNK_LO, ONE_Q, ONE_Q, ONE_Q, POW_MAX, 1, '0, 1'b1);
        add_row(MODE_UNK_HI, TERM_MAX, TERM_MAX, TERM_MAX, POW_NEG1, 1, '0, 1'b1);
        // Ambient sphere passes the constant term through.
        add_row(MODE_SPHERE, TERM_MAX, TERM_MAX, TERM_MAX, POW_MIN, 1, 32'h00FFFFFF, 1'b0);
        add_row(MODE_SPHERE, '0, '0, '0, '0, 1, '0, 1'b0);
        // Ambient box: a 3-4-5 triangle, all zero, and all terms at their maximum.
        add_row(MODE_BOX, 24'd3, 24'd4, '0, '0, 1, 32'd5, 1'b0);
        add_row(MODE_BOX, '0, '0, '0, POW_MAX, 1, '0, 1'b0);
        add_row(MODE_BOX, TERM_MAX, TERM_MAX, TERM_MAX, POW_MIN, 0, '0, 1'b0);
        // Dark light: already below threshold at distance zero.
        add_row(MODE_POINT, 24'd1, '0, '0, '0, 1, '0, 1'b0);
        // Steepest falloff against the brightest intensity: a short walk from zero.
        add_row(MODE_POINT, TERM_MAX, TERM_MAX, TERM_MAX, POW_MAX, 0, '0, 1'b0);
        // Little or no attenuation: unbounded, also for the most negative intensity and for -1.
        add_row(MODE_POINT, '0, '0, '0, 24'd1, 1, '0, 1'b1);
        add_row(MODE_SPOT, '0, '0, '0, POW_MIN, 1, '0, 1'b1);
        add_row(MODE_POINT, '0, '0, '0, POW_NEG1, 1, '0, 1'b1);
        add_row(MODE_POINT, '0, '0, 24'd1, POW_MAX, 1, '0, 1'b1);
        // Attenuation equal to the threshold everywhere: the walk stops at its limit.
        add_row(MODE_SPOT, 24'd255, '0, '0, 24'd1, 1, 32'h03FF0000, 1'b0);
        // Linear falloff tuned so that each probe outcome picks its own walk start.
        add_row(MODE_POINT, '0, ONE_Q, '0, 24'd2570, 0, '0, 1'b0);
        add_row(MODE_POINT, '0, ONE_Q, '0, 24'd7710, 0, '0, 1'b0);
        add_row(MODE_SPOT, '0, ONE_Q, '0, 24'd17990, 0, '0, 1'b0);
        add_row(MODE_POINT, '0, ONE_Q, '0, 24'd51400, 0, '0, 1'b0);
        add_row(MODE_SPOT, '0, ONE_Q, '0, 24'd77101, 0, '0, 1'b0);
        add_row(MODE_POINT, '0, ONE_Q, '0, 24'd154202, 0, '0, 1'b0);
        add_row(MODE_SPOT, '0, ONE_Q, '0, POW_W'(-24'sd205603), 0, '0, 1'b0);
        // Radius lands exactly on the far probe.
        add_row(MODE_POINT, '0, ONE_Q, '0, 24'd257003, 0, '0, 1'b0);
        // Quadratic falloff with a negative intensity.
        add_row(MODE_SPOT, 24'd1000, '0, ONE_Q, POW_W'(-24'sd100000), 0, '0, 1'b0);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            want = directed_rows[i].known ? directed_rows[i].res
                                          : predict_range(directed_rows[i].light);
            send_light(directed_rows[i].light, want);
        end

        // Three phases: sender idles more lightly, then heavily, then neither side idles.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    in_gap_pct    = 29;
                    out_stall_pct = 46;
                end
                1:
                begin
                    in_gap_pct    = 46;
                    out_stall_pct = 29;
                end
                default:
                begin
                    in_gap_pct    = 0;
                    out_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_WORDS / 3; n++)
            begin
                w = random_light();
                send_light(w, predict_range(w));
            end
        end
        in_valid = 1'b0;

        // Let the last results drain, then give the block time to show any extra word.
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/ler_pkg.sv
sv/ler_ctrl.sv
sv/ler_datapath.sv
sv/light_effect_range.sv
sv/ler_checker.sv
verif/tb.sv
